[rtl/core/abkf_pkg.sv]
// Shared types, constants and arithmetic helpers of the angle/bias Kalman filter.
`timescale 1ns / 1ps

package abkf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int COV_FRAC_BITS   = 30;

    localparam logic [30:0] RST_ANGLE_NOISE   = 31'd1073742;
    localparam logic [30:0] RST_BIAS_NOISE    = 31'd3221226;
    localparam logic [30:0] RST_MEASURE_NOISE = 31'd32212255;

    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RATE,
        OP_M_DT_RATE,
        OP_ANGLE,
        OP_M_DT_P11,
        OP_INNER,
        OP_M_DT_INNER,
        OP_P00,
        OP_M_QB_DT,
        OP_P11,
        OP_DIV0,
        OP_K0,
        OP_DIV1,
        OP_K1,
        OP_ZERO_K,
        OP_M_K0Y,
        OP_ANG2,
        OP_M_K1Y,
        OP_BIAS,
        OP_M_K1P01,
        OP_C11,
        OP_M_K0P01,
        OP_C01,
        OP_M_K1P00,
        OP_C10,
        OP_M_K0P00,
        OP_C00,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic s_pos;
        logic out_block;
    } status_t;

    // round to nearest, ties toward plus infinity, then arithmetic shift
    function automatic logic signed [68:0] rnd_shr(input logic signed [68:0] v,
                                                   input logic [5:0] s);
        logic signed [68:0] half;
        half = 69'sd1 <<< (s - 6'd1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -72'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/core/abkf_divider.sv]
// Radix-2 restoring divider for the Kalman gains: sat32((num << 30) / den).
`timescale 1ns / 1ps

module abkf_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic        [33:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic [32:0] mag;
    logic [30:0] hi;
    logic [34:0] shifted;
    logic [34:0] trial;

    logic [33:0] rem_reg,  rem_next;
    logic [31:0] lo_reg,   lo_next;
    logic [31:0] q_reg,    q_next;
    logic [5:0]  cnt_reg,  cnt_next;
    logic        ovf_reg,  ovf_next;
    logic        neg_reg,  neg_next;
    logic        done_reg, done_next;

    // magnitude of the dividend num * 2^30; top part seeds the remainder
    assign mag     = num[31] ? (33'd0 - {num[31], num}) : {1'b0, num};
    assign hi      = mag[32:2];
    assign shifted = {rem_reg, lo_reg[31]};
    assign trial   = shifted - {1'b0, den};

    always_comb
    begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = {3'b0, hi};
            lo_next  = {mag[1:0], 30'b0};
            q_next   = '0;
            cnt_next = 6'd32;
            ovf_next = ({3'b0, hi} >= den);
            neg_next = num[31];
        end
        else if (cnt_reg != 6'd0)
        begin
            if (shifted >= {1'b0, den})
            begin
                rem_next = trial[33:0];
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[33:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            lo_next   = {lo_reg[30:0], 1'b0};
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (ovf_reg)
            quot = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (!neg_reg)
            quot = q_reg[31] ? 32'sh7FFF_FFFF : $signed(q_reg);
        else if (q_reg > 32'h8000_0000)
            quot = 32'sh8000_0000;
        else
            quot = $signed(32'd0 - q_reg);
    end

    assign done = done_reg;

endmodule

[rtl/core/abkf_datapath.sv]
// Filter datapath: state, covariance, shared multiplier, divider and result register.
`timescale 1ns / 1ps

module abkf_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  abkf_pkg::cmd_t        cmd,
    output abkf_pkg::status_t     status,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_data,
    input  logic signed [31:0]    measured_angle,
    input  logic signed [31:0]    gyro_rate,
    input  logic [16:0]           time_step,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    filtered_angle
);

    localparam logic [5:0] AFB = 6'(abkf_pkg::ANGLE_FRAC_BITS);
    localparam logic [5:0] CFB = 6'(abkf_pkg::COV_FRAC_BITS);

    logic [30:0] an_reg, bn_reg, mn_reg;
    logic signed [31:0] angle_reg, bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic               out_valid_reg;

    logic signed [31:0] meas_reg, gyro_reg, rate_reg, y_reg, k0_reg, k1_reg;
    logic [16:0]        dt_reg;
    logic signed [33:0] dtp11_reg, s_reg;
    logic signed [35:0] inner_reg;
    logic signed [68:0] prod_reg;
    logic signed [31:0] out_data_reg;

    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [68:0] mul_p;
    logic signed [68:0] sh_a;
    logic signed [68:0] sh_c;
    logic signed [33:0] dtp11_new;
    logic signed [31:0] div_num;
    logic               div_done;
    logic signed [31:0] div_quot;

    // shared multiplier operand selection
    always_comb
    begin
        case (cmd.op)
            abkf_pkg::OP_M_DT_RATE:
            begin
                mul_a = $signed({19'b0, dt_reg});
                mul_b = 33'(rate_reg);
            end
            abkf_pkg::OP_M_DT_P11:
            begin
                mul_a = $signed({19'b0, dt_reg});
                mul_b = 33'(p11_reg);
            end
            abkf_pkg::OP_M_DT_INNER:
            begin
                mul_a = inner_reg;
                mul_b = $signed({16'b0, dt_reg});
            end
            abkf_pkg::OP_M_QB_DT:
            begin
                mul_a = $signed({5'b0, bn_reg});
                mul_b = $signed({16'b0, dt_reg});
            end
            abkf_pkg::OP_M_K0Y:
            begin
                mul_a = 36'(k0_reg);
                mul_b = 33'(y_reg);
            end
            abkf_pkg::OP_M_K1Y:
            begin
                mul_a = 36'(k1_reg);
                mul_b = 33'(y_reg);
            end
            abkf_pkg::OP_M_K1P01:
            begin
                mul_a = 36'(k1_reg);
                mul_b = 33'(p01_reg);
            end
            abkf_pkg::OP_M_K0P01:
            begin
                mul_a = 36'(k0_reg);
                mul_b = 33'(p01_reg);
            end
            abkf_pkg::OP_M_K1P00:
            begin
                mul_a = 36'(k1_reg);
                mul_b = 33'(p00_reg);
            end
            abkf_pkg::OP_M_K0P00:
            begin
                mul_a = 36'(k0_reg);
                mul_b = 33'(p00_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign sh_a      = abkf_pkg::rnd_shr(prod_reg, AFB);
    assign sh_c      = abkf_pkg::rnd_shr(prod_reg, CFB);
    assign dtp11_new = 34'(sh_a);
    assign div_num   = (cmd.op == abkf_pkg::OP_DIV1) ? p10_reg : p00_reg;

    abkf_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // state that reset must initialise: config defaults, estimates, covariance, result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            an_reg        <= abkf_pkg::RST_ANGLE_NOISE;
            bn_reg        <= abkf_pkg::RST_BIAS_NOISE;
            mn_reg        <= abkf_pkg::RST_MEASURE_NOISE;
            angle_reg     <= '0;
            bias_reg      <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    abkf_pkg::REG_ANGLE_NOISE:   an_reg <= cfg_data;
                    abkf_pkg::REG_BIAS_NOISE:    bn_reg <= cfg_data;
                    abkf_pkg::REG_MEASURE_NOISE: mn_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.op == abkf_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (cmd.op)
                abkf_pkg::OP_ANGLE:
                    angle_reg <= abkf_pkg::sat32(72'(angle_reg) + 72'(sh_a));
                abkf_pkg::OP_P00:
                begin
                    p00_reg <= abkf_pkg::sat32(72'(p00_reg) + 72'(sh_a));
                    p01_reg <= abkf_pkg::sat32(72'(p01_reg) - 72'(dtp11_reg));
                    p10_reg <= abkf_pkg::sat32(72'(p10_reg) - 72'(dtp11_reg));
                end
                abkf_pkg::OP_P11:
                    p11_reg <= abkf_pkg::sat32(72'(p11_reg) + 72'(sh_a));
                abkf_pkg::OP_ANG2:
                    angle_reg <= abkf_pkg::sat32(72'(angle_reg) + 72'(sh_c));
                abkf_pkg::OP_BIAS:
                    bias_reg <= abkf_pkg::sat32(72'(bias_reg) + 72'(sh_c));
                abkf_pkg::OP_C11:
                    p11_reg <= abkf_pkg::sat32(72'(p11_reg) - 72'(sh_c));
                abkf_pkg::OP_C01:
                    p01_reg <= abkf_pkg::sat32(72'(p01_reg) - 72'(sh_c));
                abkf_pkg::OP_C10:
                    p10_reg <= abkf_pkg::sat32(72'(p10_reg) - 72'(sh_c));
                abkf_pkg::OP_C00:
                    p00_reg <= abkf_pkg::sat32(72'(p00_reg) - 72'(sh_c));
                default: ;
            endcase
        end
    end

    // working registers of one item
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (cmd.op)
            abkf_pkg::OP_LOAD:
            begin
                meas_reg <= measured_angle;
                gyro_reg <= gyro_rate;
                dt_reg   <= time_step;
            end
            abkf_pkg::OP_RATE:
                rate_reg <= abkf_pkg::sat32(72'(gyro_reg) - 72'(bias_reg));
            abkf_pkg::OP_INNER:
            begin
                dtp11_reg <= dtp11_new;
                inner_reg <= 36'(dtp11_new) - 36'(p01_reg) - 36'(p10_reg)
                             + $signed({5'b0, an_reg});
            end
            abkf_pkg::OP_P11:
            begin
                s_reg <= 34'(p00_reg) + $signed({3'b0, mn_reg});
                y_reg <= abkf_pkg::sat32(72'(meas_reg) - 72'(angle_reg));
            end
            abkf_pkg::OP_K0:
                k0_reg <= div_quot;
            abkf_pkg::OP_K1:
                k1_reg <= div_quot;
            abkf_pkg::OP_ZERO_K:
            begin
                k0_reg <= '0;
                k1_reg <= '0;
            end
            abkf_pkg::OP_OUT:
                out_data_reg <= angle_reg;
            default: ;
        endcase
    end

    assign status.div_done  = div_done;
    assign status.s_pos     = (s_reg > 34'sd0);
    assign status.out_block = out_valid_reg & out_stall;

    assign out_valid      = out_valid_reg;
    assign filtered_angle = out_data_reg;

endmodule

[rtl/core/abkf_ctrl.sv]
// Sequencer that steps the filter datapath through predict, gain and update.
`timescale 1ns / 1ps

module abkf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  abkf_pkg::status_t status,
    output abkf_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RATE, ST_M1, ST_ANG, ST_M2, ST_INNER, ST_M3, ST_P00, ST_M4,
        ST_P11, ST_CHK, ST_DIV0, ST_W0, ST_K0, ST_DIV1, ST_W1, ST_K1, ST_ZK,
        ST_MK0Y, ST_ANG2, ST_MK1Y, ST_BIAS, ST_MC11, ST_C11, ST_MC01, ST_C01,
        ST_MC10, ST_C10, ST_MC00, ST_C00, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = abkf_pkg::OP_NONE;
        cmd.div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd.op     = abkf_pkg::OP_LOAD;
                    state_next = ST_RATE;
                end
            ST_RATE:  begin cmd.op = abkf_pkg::OP_RATE;      state_next = ST_M1;    end
            ST_M1:    begin cmd.op = abkf_pkg::OP_M_DT_RATE; state_next = ST_ANG;   end
            ST_ANG:   begin cmd.op = abkf_pkg::OP_ANGLE;     state_next = ST_M2;    end
            ST_M2:    begin cmd.op = abkf_pkg::OP_M_DT_P11;  state_next = ST_INNER; end
            ST_INNER: begin cmd.op = abkf_pkg::OP_INNER;     state_next = ST_M3;    end
            ST_M3:    begin cmd.op = abkf_pkg::OP_M_DT_INNER; state_next = ST_P00;  end
            ST_P00:   begin cmd.op = abkf_pkg::OP_P00;       state_next = ST_M4;    end
            ST_M4:    begin cmd.op = abkf_pkg::OP_M_QB_DT;   state_next = ST_P11;   end
            ST_P11:   begin cmd.op = abkf_pkg::OP_P11;       state_next = ST_CHK;   end
            ST_CHK:
                state_next = status.s_pos ? ST_DIV0 : ST_ZK;
            ST_DIV0:
            begin
                cmd.op        = abkf_pkg::OP_DIV0;
                cmd.div_start = 1'b1;
                state_next    = ST_W0;
            end
            ST_W0:
                if (status.div_done)
                    state_next = ST_K0;
            ST_K0:    begin cmd.op = abkf_pkg::OP_K0;        state_next = ST_DIV1;  end
            ST_DIV1:
            begin
                cmd.op        = abkf_pkg::OP_DIV1;
                cmd.div_start = 1'b1;
                state_next    = ST_W1;
            end
            ST_W1:
                if (status.div_done)
                    state_next = ST_K1;
            ST_K1:    begin cmd.op = abkf_pkg::OP_K1;        state_next = ST_MK0Y;  end
            ST_ZK:    begin cmd.op = abkf_pkg::OP_ZERO_K;    state_next = ST_MK0Y;  end
            ST_MK0Y:  begin cmd.op = abkf_pkg::OP_M_K0Y;     state_next = ST_ANG2;  end
            ST_ANG2:  begin cmd.op = abkf_pkg::OP_ANG2;      state_next = ST_MK1Y;  end
            ST_MK1Y:  begin cmd.op = abkf_pkg::OP_M_K1Y;     state_next = ST_BIAS;  end
            ST_BIAS:  begin cmd.op = abkf_pkg::OP_BIAS;      state_next = ST_MC11;  end
            ST_MC11:  begin cmd.op = abkf_pkg::OP_M_K1P01;   state_next = ST_C11;   end
            ST_C11:   begin cmd.op = abkf_pkg::OP_C11;       state_next = ST_MC01;  end
            ST_MC01:  begin cmd.op = abkf_pkg::OP_M_K0P01;   state_next = ST_C01;   end
            ST_C01:   begin cmd.op = abkf_pkg::OP_C01;       state_next = ST_MC10;  end
            ST_MC10:  begin cmd.op = abkf_pkg::OP_M_K1P00;   state_next = ST_C10;   end
            ST_C10:   begin cmd.op = abkf_pkg::OP_C10;       state_next = ST_MC00;  end
            ST_MC00:  begin cmd.op = abkf_pkg::OP_M_K0P00;   state_next = ST_C00;   end
            ST_C00:   begin cmd.op = abkf_pkg::OP_C00;       state_next = ST_OUT;   end
            ST_OUT:
                if (!status.out_block)
                begin
                    cmd.op     = abkf_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> state_reg == ST_RATE)
        else $error("accepted beat did not start the predict sequence");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_W0 || state_reg == ST_W1))
        else $error("divider finished outside a wait state");

    a_nonpos_s: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK && !status.s_pos) |=> state_reg == ST_ZK)
        else $error("non-positive S did not zero the gains");
`endif

endmodule

[rtl/core/angle_bias_kalman_filter_unit.sv]
// Top level of the two-state angle/gyro-bias Kalman filter.
// The two 32-step gain divisions are skipped, and the gains zeroed, when
// S = P00 + R is not positive. The sequencer holds one item at a time and
// takes no new input beat until the last one has reached the result register;
// its steps share the one multiplier and the radix-2 divider.
// Reset (rst_n, async, active low): estimates and covariance cleared, noise
// registers at their defaults, no result pending.
`timescale 1ns / 1ps

module angle_bias_kalman_filter_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] gyro_rate,
    input  logic [16:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] filtered_angle
);

    abkf_pkg::cmd_t    cmd;
    abkf_pkg::status_t status;
    logic              in_ready;

    // Sequencer: walks predict, gain division and update, one step per state.
    abkf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: filter state, shared multiplier, divider, result register.
    // The result register lets a new input beat be taken while the last
    // result beat is still stalled.
    abkf_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .measured_angle (measured_angle),
        .gyro_rate      (gyro_rate),
        .time_step      (time_step),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_angle (filtered_angle)
    );

    assign in_stall = ~in_ready;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the angle/gyro-bias Kalman filter unit.
`timescale 1ns / 1ps

module tb_top;

    // Index 3 is not a register; a write there must be dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [30:0] NOISE_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] NOISE_ONE = 31'd1073741824;  // 1.0 in UQ1.30
    localparam int SETTLE_CYCLES = 120;                    // exceeds the input-to-result latency
    localparam int HOLD_CYCLES   = 400;
    localparam int AFB = abkf_pkg::ANGLE_FRAC_BITS;
    localparam int CFB = abkf_pkg::COV_FRAC_BITS;

    typedef enum logic { ROW_CFG, ROW_BEAT } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         index;
        logic [30:0]        value;
        logic signed [31:0] meas;
        logic signed [31:0] gyro;
        logic [16:0]        dt;
        logic               typed;   // expected value given in the row
        logic signed [31:0] angle;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
    logic [16:0]        time_step;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] filtered_angle;

    // Filter model state and noise settings
    longint      angle_est;
    longint      bias_est;
    longint      cov [4];
    logic [30:0] q_angle;
    logic [30:0] q_bias;
    logic [30:0] r_meas;

    logic signed [31:0] pending_angles [$];
    int n_errors;
    int n_beats_in;
    int n_beats_out;
    int n_cfg_writes;
    int n_settings;
    longint track_angle;   // slowly moving "true" angle for realistic samples

    angle_bias_kalman_filter_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measured_angle (measured_angle),
        .gyro_rate      (gyro_rate),
        .time_step      (time_step),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_angle (filtered_angle)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("Timeout: %0d beats in, %0d out", n_beats_in, n_beats_out);
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------
    // Fixed-point model of one filter step
    // ---------------------------------------------------------------
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // round to nearest, ties up, then arithmetic shift
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] filter_step(input logic signed [31:0] meas,
                                                       input logic signed [31:0] gyro,
                                                       input logic [16:0] dt_in);
        longint dt, rate, dtp11, inner, s, k0, k1, y;
        longint p00, p01, p10, p11;
        dt  = longint'(dt_in);
        p00 = cov[0];
        p01 = cov[1];
        p10 = cov[2];
        p11 = cov[3];
        k0  = 0;
        k1  = 0;

        // predict
        rate      = clamp32(longint'(gyro) - bias_est);
        angle_est = clamp32(angle_est + round_shift(dt * rate, AFB));
        dtp11     = round_shift(dt * p11, AFB);
        inner     = dtp11 - p01 - p10 + longint'(q_angle);
        p00       = clamp32(p00 + round_shift(dt * inner, AFB));
        p01       = clamp32(p01 - dtp11);
        p10       = clamp32(p10 - dtp11);
        p11       = clamp32(p11 + round_shift(longint'(q_bias) * dt, AFB));

        // gains; a non-positive S leaves the prediction untouched
        s = p00 + longint'(r_meas);
        if (s > 0)
        begin
            k0 = clamp32((p00 <<< CFB) / s);
            k1 = clamp32((p10 <<< CFB) / s);
        end

        // update
        y         = clamp32(longint'(meas) - angle_est);
        angle_est = clamp32(angle_est + round_shift(k0 * y, CFB));
        bias_est  = clamp32(bias_est + round_shift(k1 * y, CFB));
        cov[0]    = clamp32(p00 - round_shift(k0 * p00, CFB));
        cov[1]    = clamp32(p01 - round_shift(k0 * p01, CFB));
        cov[2]    = clamp32(p10 - round_shift(k1 * p00, CFB));
        cov[3]    = clamp32(p11 - round_shift(k1 * p01, CFB));
        return angle_est[31:0];
    endfunction

    // ---------------------------------------------------------------
    // Driving side
    // ---------------------------------------------------------------
    task automatic write_noise(input logic [1:0] index, input logic [30:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            abkf_pkg::REG_ANGLE_NOISE:   q_angle = value;
            abkf_pkg::REG_BIAS_NOISE:    q_bias  = value;
            abkf_pkg::REG_MEASURE_NOISE: r_meas  = value;
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    // Block must be idle before a register write: drain, then cover latency.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offers one beat, holds it until accepted, then maybe leaves a gap.
    task automatic send_beat(input logic signed [31:0] meas,
                             input logic signed [31:0] gyro,
                             input logic [16:0] dt,
                             input logic typed,
                             input logic signed [31:0] angle);
        logic signed [31:0] predicted;
        int gap;
        in_valid       <= 1'b1;
        measured_angle <= meas;
        gyro_rate      <= gyro;
        time_step      <= dt;
        do
            @(posedge clk);
        while (in_stall);
        predicted = filter_step(meas, gyro, dt);
        if (typed && predicted !== angle)
            $display("Note: typed row value %0d differs from model %0d", angle, predicted);
        pending_angles.push_back(typed ? angle : predicted);
        n_beats_in++;

        // mostly back to back or short gaps, now and then a long one
        case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            9:          gap = $urandom_range(20, 120);
            default:    gap = $urandom_range(1, 4);
        endcase
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic signed [31:0] meas;
        logic signed [31:0] gyro;
        logic [16:0]        dt;
        int                 jitter;
        if ($urandom_range(0, 9) < 7)
        begin
            // plausible IMU sample: slow angle drift, modest rate, small dt
            track_angle = track_angle + (longint'($urandom_range(0, 131072)) - 65536);
            jitter      = int'($urandom_range(0, 262144)) - 131072;
            meas        = 32'(clamp32(track_angle + jitter));
            gyro        = int'($urandom_range(0, 4194304)) - 2097152;
            dt          = 17'($urandom_range(1, 2000));
        end
        else
        begin
            // full-range noise, including time steps beyond one second
            meas = $urandom;
            gyro = $urandom;
            dt   = 17'($urandom_range(0, 131071));
        end
        send_beat(meas, gyro, dt, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall plus one long hold-off
    // ---------------------------------------------------------------
    initial
    begin
        int hold;
        bit quiet;
        out_stall = 1'b0;
        @(posedge rst_n);
        while (n_beats_in < 40)
            @(posedge clk);
        // Long hold: sender keeps offering, the unit fills and stalls input.
        out_stall <= 1'b1;
        for (hold = 0; hold < HOLD_CYCLES; hold++)
            @(posedge clk);
        forever
        begin
            quiet = ($urandom_range(0, 3) == 0);
            repeat (64)
            begin
                if (!quiet && $urandom_range(0, 199) == 0)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(50, 200)) @(posedge clk);
                end
                else
                begin
                    if (quiet || $urandom_range(0, 3) != 0)
                        out_stall <= 1'b0;
                    else
                        out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_beats_out++;
            if (pending_angles.size() == 0)
            begin
                $error("filtered_angle: unexpected beat, value %0d", filtered_angle);
                n_errors++;
            end
            else
            begin
                if (filtered_angle !== pending_angles[0])
                begin
                    $error("filtered_angle: expected %0d, actual %0d",
                           pending_angles[0], filtered_angle);
                    n_errors++;
                end
                void'(pending_angles.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    row_t directed [$];

    function automatic row_t cfg_row(input logic [1:0] index, input logic [30:0] value);
        row_t r;
        r       = '{kind: ROW_CFG, default: '0};
        r.index = index;
        r.value = value;
        return r;
    endfunction

    function automatic row_t beat_row(input logic signed [31:0] meas,
                                      input logic signed [31:0] gyro,
                                      input logic [16:0] dt,
                                      input logic typed,
                                      input logic signed [31:0] angle);
        row_t r;
        r       = '{kind: ROW_BEAT, default: '0};
        r.meas  = meas;
        r.gyro  = gyro;
        r.dt    = dt;
        r.typed = typed;
        r.angle = angle;
        return r;
    endfunction

    initial
    begin
        logic [30:0] settings [8][3];
        int k;
        int j;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = abkf_pkg::REG_ANGLE_NOISE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        measured_angle = '0;
        gyro_rate      = '0;
        time_step      = '0;
        n_errors       = 0;
        n_beats_in     = 0;
        n_beats_out    = 0;
        n_cfg_writes   = 0;
        n_settings     = 0;
        track_angle    = 0;
        angle_est      = 0;
        bias_est       = 0;
        cov            = '{0, 0, 0, 0};
        q_angle        = abkf_pkg::RST_ANGLE_NOISE;
        q_bias         = abkf_pkg::RST_BIAS_NOISE;
        r_meas         = abkf_pkg::RST_MEASURE_NOISE;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // S = 0 right after reset (P00 = 0, R = 0, dt = 0): gains stay zero
        directed.push_back(cfg_row(abkf_pkg::REG_MEASURE_NOISE, '0));
        directed.push_back(beat_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'd0, 1'b1, 32'sd0));
        directed.push_back(beat_row(32'sh8000_0000, 32'sh8000_0000, 17'd0, 1'b1, 32'sd0));
        directed.push_back(cfg_row(abkf_pkg::REG_MEASURE_NOISE,
                                   abkf_pkg::RST_MEASURE_NOISE));
        // write to a non-existent register is ignored
        directed.push_back(cfg_row(REG_UNUSED, NOISE_MAX));
        directed.push_back(beat_row(32'sd0, 32'sd0, 17'd0, 1'b1, 32'sd0));
        // field extremes; time steps at and beyond one second
        directed.push_back(beat_row(32'sh7FFF_FFFF, 32'sd0, 17'd65536, 1'b0, '0));
        directed.push_back(beat_row(32'sh8000_0000, 32'sh7FFF_FFFF, 17'd65536, 1'b0, '0));
        directed.push_back(beat_row(32'sd0, 32'sh8000_0000, 17'd131071, 1'b0, '0));
        directed.push_back(beat_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'd131071, 1'b0, '0));
        directed.push_back(beat_row(32'sh8000_0000, 32'sh8000_0000, 17'd1, 1'b0, '0));
        directed.push_back(beat_row(32'sd65536, 32'sd131072, 17'd655, 1'b0, '0));
        directed.push_back(beat_row(-32'sd65536, -32'sd131072, 17'd655, 1'b0, '0));
        // tiny R with large covariance drives the gains to saturation
        directed.push_back(cfg_row(abkf_pkg::REG_MEASURE_NOISE, 31'd1));
        directed.push_back(cfg_row(abkf_pkg::REG_ANGLE_NOISE, NOISE_MAX));
        directed.push_back(cfg_row(abkf_pkg::REG_BIAS_NOISE, NOISE_MAX));
        directed.push_back(beat_row(32'sd1000000, 32'sd5000, 17'd131071, 1'b0, '0));
        directed.push_back(beat_row(-32'sd1000000, -32'sd5000, 17'd131071, 1'b0, '0));
        directed.push_back(beat_row(32'sd12345, 32'sd0, 17'd0, 1'b0, '0));

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_noise(directed[i].index, directed[i].value);
            end
            else
                send_beat(directed[i].meas, directed[i].gyro, directed[i].dt,
                          directed[i].typed, directed[i].angle);
        end

        // Noise settings for the random phases: angle, bias, measurement
        settings[0] = '{abkf_pkg::RST_ANGLE_NOISE, abkf_pkg::RST_BIAS_NOISE,
                        abkf_pkg::RST_MEASURE_NOISE};
        settings[1] = '{31'd0, 31'd0, 31'd1};
        settings[2] = '{NOISE_ONE, NOISE_ONE, NOISE_ONE};
        settings[3] = '{NOISE_MAX, NOISE_MAX, NOISE_MAX};
        settings[4] = '{31'd0, NOISE_MAX, 31'd1};
        settings[5] = '{NOISE_MAX, 31'd0, 31'd0};
        settings[6] = '{31'd1073742, 31'd100, 31'd500000000};
        settings[7] = '{abkf_pkg::RST_ANGLE_NOISE, abkf_pkg::RST_BIAS_NOISE,
                        abkf_pkg::RST_MEASURE_NOISE};

        for (k = 0; k < 8; k++)
        begin
            wait_drained();
            write_noise(abkf_pkg::REG_ANGLE_NOISE, settings[k][0]);
            write_noise(abkf_pkg::REG_BIAS_NOISE, settings[k][1]);
            write_noise(abkf_pkg::REG_MEASURE_NOISE, settings[k][2]);
            n_settings++;
            for (j = 0; j < 48; j++)
                send_random();
        end
        in_valid <= 1'b0;

        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d input beats and %0d results under %0d noise settings,",
                 n_beats_in, n_beats_out, n_settings);
        $display("with %0d register writes, a long output hold-off and random gaps.",
                 n_cfg_writes);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
